[design/key_combo_crash_detector_macros.svh]
// ----------------------------------------------------------------------------
// Key combo crash detector assertion macros
// Shared concurrent assertion forms; ASSERT_OFF leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef KEY_COMBO_CRASH_DETECTOR_MACROS_SVH
`define KEY_COMBO_CRASH_DETECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define CKD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CKD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CKD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CKD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/ckd_pkg.sv]
// ----------------------------------------------------------------------------
// Key combo crash detector package
// Constants, combo descriptor, command/status bundles and combo decoder.
// ----------------------------------------------------------------------------
package ckd_pkg;

   localparam int unsigned CKD_NUM_COMBOS = 2;
   localparam int unsigned CKD_MAX_KEYS   = 15;
   localparam int unsigned SLOT_KEYS      = 15;
   localparam int unsigned CFG_W          = 50;

   localparam logic [2:0]  POWER_KEY   = 3'd2;
   localparam logic [15:0] DEF_TMO_MS  = 16'd1000;

   localparam logic [CFG_W-1:0] COMBO_A_RST = 50'd4611;
   localparam logic [15:0]      HOLD_TMO_RST = 16'd6000;
   localparam logic [4:0]       HOLD_MASK_RST = 5'd5;

   // register indexes
   localparam logic [2:0] CSR_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_COMBO_A   = 3'd1;
   localparam logic [2:0] CSR_COMBO_B   = 3'd2;
   localparam logic [2:0] CSR_TMO_A     = 3'd3;
   localparam logic [2:0] CSR_TMO_B     = 3'd4;
   localparam logic [2:0] CSR_HOLD_MASK = 3'd5;
   localparam logic [2:0] CSR_HOLD_TMO  = 3'd6;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] UC_NONE  = 2'd0;
   localparam logic [1:0] UC_INIT  = 2'd1;
   localparam logic [1:0] UC_POWER = 2'd2;

   typedef struct packed {
      logic                       valid;
      logic                       is_long;
      logic [3:0]                 len;
      logic [SLOT_KEYS-1:0][2:0]  keys;
      logic [2:0]                 trigger;
      logic [3:0]                 knocks;
      logic [3:0]                 ul;       // number of unlock keys
      logic [15:0]                timeout;
   } combo_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic search;
      logic final_chk;
      logic load_rsp;
   } ckd_cmd_type;

   typedef struct packed {
      logic exec_retry;
      logic exec_search;
      logic exec_final;
      logic srch_found;
      logic srch_miss;
   } ckd_sts_type;

   function automatic combo_type ckd_decode(input logic [CFG_W-1:0] w,
                                            input logic [15:0] t,
                                            input logic in_range,
                                            input logic [3:0] max_keys);
      combo_type c;
      logic [3:0] tpos;
      c = '0;
      tpos = 4'd0;
      c.len = w[3:0];
      c.is_long = w[4];
      for (int i = 0; i < SLOT_KEYS; i++) begin
         c.keys[i] = w[5+3*i +: 3];
      end
      c.timeout = (t == 16'd0) ? DEF_TMO_MS : t;
      c.valid = in_range && (c.len >= 4'd2) && (c.len <= max_keys);
      if (c.valid) begin
         tpos = c.len - 4'd1;
         c.trigger = c.keys[tpos];
         if (c.is_long) begin
            c.knocks = tpos;
            c.ul = 4'd1;
         end else begin
            // unlock keys end after the last key that differs from the trigger
            for (int j = 0; j < SLOT_KEYS - 1; j++) begin
               if ((4'(j) < tpos) && (c.keys[j] != c.trigger)) begin
                  c.ul = 4'(j + 1);
               end
            end
            c.knocks = c.len - c.ul;
         end
      end
      return c;
   endfunction

   function automatic logic [SLOT_KEYS-1:0] ckd_unlock_mask(input logic [3:0] ul);
      return (15'(1) << ul) - 15'd1;
   endfunction

endpackage

[design/ckd_datapath.sv]
// ----------------------------------------------------------------------------
// Key combo crash detector datapath
// Config registers, detector state, key store, search and result registers.
// ----------------------------------------------------------------------------
`include "key_combo_crash_detector_macros.svh"

module ckd_datapath #(
   parameter int unsigned MAX_KEYS = ckd_pkg::CKD_MAX_KEYS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [49:0]               csr_wdata,
   input  logic                      req_operation,
   input  logic [2:0]                req_key,
   input  logic                      req_pressed,
   input  ckd_pkg::ckd_cmd_type      cmd,
   output ckd_pkg::ckd_sts_type      sts,
   output logic                      rsp_combo_fire,
   output logic                      rsp_combo_fired_index,
   output logic                      rsp_combo_fired_long,
   output logic                      rsp_hold_fire,
   output logic [1:0]                rsp_upload_cause
);
   import ckd_pkg::*;

   localparam int unsigned KW      = $clog2(MAX_KEYS);
   localparam logic [3:0]  MAX_CNT = 4'(MAX_KEYS);

   // config
   logic             enable_ff;
   logic [CFG_W-1:0] combo_a_ff, combo_b_ff;
   logic [15:0]      tmo_a_ff, tmo_b_ff, hold_tmo_ff;
   logic [4:0]       hold_mask_ff;

   // latched word
   logic       op_ff, pressed_ff;
   logic [2:0] key_ff;

   // detector state
   logic [31:0]          now_ff, now_in;
   logic [2:0]           stored_ff [MAX_KEYS];
   logic [3:0]           sc_ff, sc_in;
   logic                 cur_ff, cur_in;
   logic [SLOT_KEYS-1:0] useen_ff, useen_in;
   logic [3:0]           knock_ff, knock_in;
   logic                 uv_ff, uv_in, tv_ff, tv_in;
   logic [31:0]          ut_ff, ut_in, tt_ff, tt_in;
   logic                 stray_ff, stray_in;
   logic [4:0]           hmap_ff, hmap_in;
   logic                 cdl_act_ff, cdl_act_in, cdl_idx_ff, cdl_idx_in;
   logic [31:0]          cdl_t_ff, cdl_t_in;
   logic                 hdl_act_ff, hdl_act_in;
   logic [31:0]          hdl_t_ff, hdl_t_in;
   logic [1:0]           srch_idx_ff, srch_idx_in;
   logic [3:0]           pos_ff, pos_in;

   // result of the current word, then the output register
   logic       res_fire_ff, res_fire_in, res_idx_ff, res_idx_in;
   logic       res_long_ff, res_long_in, res_hold_ff, res_hold_in;
   logic [1:0] res_uc_ff, res_uc_in;
   logic       rsp_fire_ff, rsp_idx_ff, rsp_long_ff, rsp_hold_ff;
   logic [1:0] rsp_uc_ff;

   combo_type            dec0, dec1, dec_cur, dec_srch, dec_um;
   logic                 fv, srch_end, st_we, clr_all, clr_to;
   logic [SLOT_KEYS-1:0] um_bits, useen_new;
   logic                 um_hit, um_full;
   logic [3:0]           sc_inc;
   logic [2:0]           st_rd;
   logic [7:0]           hbit8;
   logic [4:0]           hbit, hmap_new;
   logic                 hold_hit;
   logic [31:0]          now_inc, hdl_diff, cdl_diff, order_diff, span;
   logic                 hold_due, cdl_due, order_ok, in_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         combo_a_ff   <= COMBO_A_RST;
         combo_b_ff   <= '0;
         tmo_a_ff     <= DEF_TMO_MS;
         tmo_b_ff     <= DEF_TMO_MS;
         hold_mask_ff <= HOLD_MASK_RST;
         hold_tmo_ff  <= HOLD_TMO_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_COMBO_A:   combo_a_ff   <= csr_wdata;
            CSR_COMBO_B:   combo_b_ff   <= csr_wdata;
            CSR_TMO_A:     tmo_a_ff     <= csr_wdata[15:0];
            CSR_TMO_B:     tmo_b_ff     <= csr_wdata[15:0];
            CSR_HOLD_MASK: hold_mask_ff <= csr_wdata[4:0];
            CSR_HOLD_TMO:  hold_tmo_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign dec0 = ckd_decode(combo_a_ff, tmo_a_ff, 1'(CKD_NUM_COMBOS > 0), MAX_CNT);
   assign dec1 = ckd_decode(combo_b_ff, tmo_b_ff, 1'(CKD_NUM_COMBOS > 1), MAX_CNT);
   assign fv       = !dec0.valid && dec1.valid;
   assign dec_cur  = cur_ff ? dec1 : dec0;
   assign srch_end = srch_idx_ff >= 2'(CKD_NUM_COMBOS);
   assign dec_srch = (srch_idx_ff == 2'd0) ? dec0 : ((srch_idx_ff == 2'd1) ? dec1 : '0);
   assign dec_um   = cmd.search ? dec_srch : dec_cur;

   always_comb begin
      for (int i = 0; i < SLOT_KEYS; i++) begin
         um_bits[i] = (4'(i) < dec_um.ul) && (dec_um.keys[i] == key_ff);
      end
   end
   assign useen_new = useen_ff | um_bits;
   assign um_hit    = |um_bits;
   assign um_full   = useen_new == ckd_unlock_mask(dec_um.ul);

   assign sc_inc = sc_ff + 4'd1;
   assign st_rd  = stored_ff[pos_ff[KW-1:0]];

   assign hbit8    = 8'd1 << key_ff;
   assign hbit     = hbit8[4:0];
   assign hold_hit = enable_ff && (|(hbit & hold_mask_ff));
   assign hmap_new = (hmap_ff & ~hbit) | (pressed_ff ? hbit : 5'd0);

   assign now_inc  = now_ff + 32'd1;
   assign hdl_diff = now_inc - hdl_t_ff;
   assign cdl_diff = now_inc - cdl_t_ff;
   assign hold_due = hdl_act_ff && !hdl_diff[31];
   assign cdl_due  = cdl_act_ff && !cdl_diff[31];

   assign order_diff = ut_ff - tt_ff;
   assign order_ok   = order_diff[31];
   assign span       = tt_ff - ut_ff;
   assign in_time    = span < {16'd0, dec_cur.timeout};

   always_comb begin
      now_in = now_ff;      sc_in = sc_ff;         cur_in = cur_ff;
      useen_in = useen_ff;  knock_in = knock_ff;
      uv_in = uv_ff;        ut_in = ut_ff;         tv_in = tv_ff;     tt_in = tt_ff;
      stray_in = stray_ff;  hmap_in = hmap_ff;
      cdl_act_in = cdl_act_ff; cdl_t_in = cdl_t_ff; cdl_idx_in = cdl_idx_ff;
      hdl_act_in = hdl_act_ff; hdl_t_in = hdl_t_ff;
      srch_idx_in = srch_idx_ff; pos_in = pos_ff;
      res_fire_in = res_fire_ff; res_idx_in = res_idx_ff; res_long_in = res_long_ff;
      res_hold_in = res_hold_ff; res_uc_in = res_uc_ff;
      sts = '0;
      st_we = 1'b0;
      clr_all = 1'b0;
      clr_to = 1'b0;

      if (cmd.accept) begin
         res_fire_in = 1'b0; res_idx_in = 1'b0; res_long_in = 1'b0;
         res_hold_in = 1'b0; res_uc_in = UC_NONE;
      end else if (cmd.exec) begin
         if (op_ff == OP_TICK) begin
            now_in = now_inc;
            if (hold_due) begin
               hdl_act_in = 1'b0;
               res_hold_in = 1'b1;
               res_uc_in = UC_POWER;
            end
            if (cdl_due) begin
               cdl_act_in = 1'b0;
               res_fire_in = 1'b1;
               res_idx_in = cdl_idx_ff;
               res_long_in = 1'b1;
            end
         end else begin
            // hold detector
            if (hold_hit) begin
               hmap_in = hmap_new;
               if (pressed_ff) begin
                  if (hmap_new == hold_mask_ff) begin
                     hdl_act_in = 1'b1;
                     hdl_t_in = now_ff + {16'd0, hold_tmo_ff};
                  end
               end else begin
                  hdl_act_in = 1'b0;
               end
            end
            // combo detector
            cdl_act_in = 1'b0;
            if (!pressed_ff) begin
               res_uc_in = UC_INIT;
               if (!dec_cur.valid || (useen_ff != ckd_unlock_mask(dec_cur.ul))
                   || (key_ff != dec_cur.trigger)) begin
                  clr_all = 1'b1;
               end
            end else begin
               if (key_ff == POWER_KEY) begin
                  res_uc_in = UC_POWER;
               end
               if (enable_ff) begin
                  if (!dec_cur.valid) begin
                     clr_all = 1'b1;
                     sts.exec_retry = dec0.valid || dec1.valid;
                  end else begin
                     st_we = 1'b1;
                     sc_in = sc_inc;
                     if (um_hit) begin
                        useen_in = useen_new;
                        if (um_full && !uv_ff) begin
                           uv_in = 1'b1;
                           ut_in = now_ff;
                        end
                        sts.exec_final = 1'b1;
                     end else if ((key_ff == dec_cur.trigger) && (sc_inc <= dec_cur.len)) begin
                        tv_in = 1'b1;
                        tt_in = now_ff;
                        knock_in = knock_ff + 4'd1;
                        sts.exec_final = 1'b1;
                     end else begin
                        sts.exec_search = 1'b1;
                        srch_idx_in = {1'b0, cur_ff} + 2'd1;
                        pos_in = 4'd0;
                     end
                  end
               end
            end
         end
      end else if (cmd.search) begin
         if (srch_end) begin
            stray_in = 1'b1;
            clr_to = 1'b1;
            sts.srch_miss = 1'b1;
         end else if (!dec_srch.valid || (dec_srch.len < sc_ff)
                      || (st_rd != dec_srch.keys[pos_ff])) begin
            srch_idx_in = srch_idx_ff + 2'd1;
            pos_in = 4'd0;
         end else if (pos_ff == sc_ff - 4'd1) begin
            cur_in = srch_idx_ff[0];
            if (um_hit) begin
               useen_in = useen_new;
               if (um_full && !uv_ff) begin
                  uv_in = 1'b1;
                  ut_in = now_ff;
               end
            end else begin
               tv_in = 1'b1;
               tt_in = now_ff;
               knock_in = knock_ff + 4'd1;
            end
            sts.srch_found = 1'b1;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end else if (cmd.final_chk) begin
         if (uv_ff && tv_ff && !stray_ff && order_ok) begin
            if (in_time) begin
               if (knock_ff == dec_cur.knocks) begin
                  if (dec_cur.is_long) begin
                     cdl_act_in = 1'b1;
                     cdl_t_in = now_ff + {16'd0, dec_cur.timeout};
                     cdl_idx_in = cur_ff;
                  end else begin
                     res_fire_in = 1'b1;
                     res_idx_in = cur_ff;
                     res_long_in = 1'b0;
                  end
               end
            end else begin
               clr_all = 1'b1;
            end
         end
         if (sc_ff >= MAX_CNT) begin
            clr_all = 1'b1;
         end
      end

      // detector clear, always the last action of a step
      if (clr_all) begin
         stray_in = 1'b0;
      end
      if (clr_all || clr_to) begin
         sc_in = 4'd0;
         cur_in = fv;
         uv_in = 1'b0;
         ut_in = '0;
         tv_in = 1'b0;
         tt_in = '0;
         useen_in = '0;
         knock_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;      sc_ff <= '0;       cur_ff <= 1'b0;
         useen_ff <= '0;    knock_ff <= '0;
         uv_ff <= 1'b0;     ut_ff <= '0;       tv_ff <= 1'b0;     tt_ff <= '0;
         stray_ff <= 1'b0;  hmap_ff <= '0;
         cdl_act_ff <= 1'b0; hdl_act_ff <= 1'b0;
         srch_idx_ff <= '0; pos_ff <= '0;
         res_fire_ff <= 1'b0; res_idx_ff <= 1'b0; res_long_ff <= 1'b0;
         res_hold_ff <= 1'b0; res_uc_ff <= UC_NONE;
         rsp_fire_ff <= 1'b0; rsp_idx_ff <= 1'b0; rsp_long_ff <= 1'b0;
         rsp_hold_ff <= 1'b0; rsp_uc_ff <= UC_NONE;
      end else begin
         now_ff <= now_in;      sc_ff <= sc_in;       cur_ff <= cur_in;
         useen_ff <= useen_in;  knock_ff <= knock_in;
         uv_ff <= uv_in;        ut_ff <= ut_in;       tv_ff <= tv_in;     tt_ff <= tt_in;
         stray_ff <= stray_in;  hmap_ff <= hmap_in;
         cdl_act_ff <= cdl_act_in; hdl_act_ff <= hdl_act_in;
         srch_idx_ff <= srch_idx_in; pos_ff <= pos_in;
         res_fire_ff <= res_fire_in; res_idx_ff <= res_idx_in; res_long_ff <= res_long_in;
         res_hold_ff <= res_hold_in; res_uc_ff <= res_uc_in;
         if (cmd.load_rsp) begin
            rsp_fire_ff <= res_fire_ff; rsp_idx_ff <= res_idx_ff;
            rsp_long_ff <= res_long_ff; rsp_hold_ff <= res_hold_ff;
            rsp_uc_ff <= res_uc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cdl_t_ff <= cdl_t_in;
      cdl_idx_ff <= cdl_idx_in;
      hdl_t_ff <= hdl_t_in;
      if (cmd.accept) begin
         op_ff <= req_operation;
         key_ff <= req_key;
         pressed_ff <= req_pressed;
      end
      if (st_we) begin
         stored_ff[sc_ff[KW-1:0]] <= key_ff;
      end
   end

   assign rsp_combo_fire        = rsp_fire_ff;
   assign rsp_combo_fired_index = rsp_idx_ff;
   assign rsp_combo_fired_long  = rsp_long_ff;
   assign rsp_hold_fire         = rsp_hold_ff;
   assign rsp_upload_cause      = rsp_uc_ff;

   `CKD_ASSERT_IMPLY(a_store_room, clock, reset, cmd.accept, sc_ff < MAX_CNT, "key store overfull between words")
   `CKD_ASSERT_IMPLY(a_search_nonempty, clock, reset, cmd.search, sc_ff != 4'd0, "search with empty key store")
   `CKD_ASSERT_IMPLY(a_fire_fields, clock, reset, !rsp_fire_ff, !rsp_idx_ff && !rsp_long_ff, "fire fields set without a fire")

endmodule

[design/ckd_ctrl.sv]
// ----------------------------------------------------------------------------
// Key combo crash detector controller
// Sequences accept, update, prefix search, fire check and result load.
// ----------------------------------------------------------------------------
`include "key_combo_crash_detector_macros.svh"

module ckd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ckd_pkg::ckd_sts_type  sts,
   output ckd_pkg::ckd_cmd_type  cmd
);
   import ckd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_FINAL  = 5'b01000,
      ST_OUT    = 5'b10000
   } ckd_state_type;

   ckd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.exec      = state_ff == ST_EXEC;
      cmd.search    = state_ff == ST_SEARCH;
      cmd.final_chk = state_ff == ST_FINAL;
      cmd.load_rsp  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.exec_retry) begin
               state_in = ST_EXEC;
            end else if (sts.exec_search) begin
               state_in = ST_SEARCH;
            end else if (sts.exec_final) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SEARCH: begin
            if (sts.srch_found) begin
               state_in = ST_FINAL;
            end else if (sts.srch_miss) begin
               state_in = ST_OUT;
            end
         end
         ST_FINAL: state_in = ST_OUT;
         ST_OUT: begin
            if (cmd.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `CKD_ASSERT_NEXT(a_accept_exec, clock, reset, cmd.accept, state_ff == ST_EXEC, "accepted word not executed")
   `CKD_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_rsp, rsp_valid_ff && (state_ff == ST_IDLE), "result load lost")
   `CKD_ASSERT_IMPLY(a_search_sts, clock, reset, state_ff == ST_SEARCH, !(sts.srch_found && sts.srch_miss), "search both hit and missed")

endmodule

[design/key_combo_crash_detector.sv]
// ----------------------------------------------------------------------------
// Key combo crash detector
// Detects programmed key combinations and a key-hold hard reset from key
// events and one-millisecond ticks; reports upload-cause hints.
// ----------------------------------------------------------------------------
//  channel | ports                         | dir | word
//  req     | req_valid / req_stall         | in  | operation, key, pressed
//  rsp     | rsp_valid / rsp_stall         | out | fire, index, long, hold, cause
//  csr     | csr_we, csr_index, csr_wdata  | in  | one register per write
//
//  One word is in flight at a time. A tick or a release runs from accept
//  through execute to result load; a press that fits the current combo adds
//  a fire check. A press that leaves it walks later combos one stored key a
//  cycle, then goes to the fire check or, on a miss, to the result load.
//  Synchronous reset sets config to defaults and clears detector state;
//  stored keys, the latched word and the deadline times are not cleared.
//  A stalled result sits in the output register; the next word is accepted
//  meanwhile and its result waits for that register to empty.
// ----------------------------------------------------------------------------
module key_combo_crash_detector #(
   parameter int unsigned MAX_KEYS = ckd_pkg::CKD_MAX_KEYS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [49:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [2:0]  req_key,
   input  logic        req_pressed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_combo_fire,
   output logic        rsp_combo_fired_index,
   output logic        rsp_combo_fired_long,
   output logic        rsp_hold_fire,
   output logic [1:0]  rsp_upload_cause
);
   import ckd_pkg::*;

   // controller <-> datapath
   ckd_cmd_type cmd;
   ckd_sts_type sts;

   ckd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath holds config, detector state, key store and result register
   ckd_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_operation         (req_operation),
      .req_key               (req_key),
      .req_pressed           (req_pressed),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_combo_fire        (rsp_combo_fire),
      .rsp_combo_fired_index (rsp_combo_fired_index),
      .rsp_combo_fired_long  (rsp_combo_fired_long),
      .rsp_hold_fire         (rsp_hold_fire),
      .rsp_upload_cause      (rsp_upload_cause)
   );

endmodule
